// ===== rtl/core/ffbpa_pkg.sv =====
package ffbpa_pkg;

  localparam int POOL_BYTES  = 16777216;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SH     = $clog2(PAGE_BYTES);
  localparam int MAX_OWNERS  = 16;
  localparam int MAX_RANGES  = 128;
  localparam int MAX_BUFFERS = 128;

  localparam int SZW = 25;

  localparam logic [2:0] OP_ALLOC      = 3'd0;
  localparam logic [2:0] OP_FREE       = 3'd1;
  localparam logic [2:0] OP_FREE_OWNER = 3'd2;
  localparam logic [2:0] OP_LOOKUP     = 3'd3;
  localparam logic [2:0] OP_MAP        = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOMEM    = 3'd2;
  localparam logic [2:0] ST_QUOTA    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_NODEV    = 3'd5;

  localparam logic [3:0] REG_MAX_BUF = 4'd0;
  localparam logic [3:0] REG_QUOTA   = 4'd1;
  localparam logic [3:0] REG_MMAP    = 4'd2;
  localparam logic [3:0] REG_DMA     = 4'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  owner_id;
    logic [31:0] alloc_bytes;
    logic [31:0] handle;
    logic [31:0] data_offset;
    logic [31:0] length;
  } in_t;

  typedef struct packed {
    logic [2:0]     status;
    logic [31:0]    new_handle;
    logic [31:0]    map_offset;
    logic [SZW-1:0] granted_size;
    logic [63:0]    dma_address;
    logic [12:0]    page_index;
  } out_t;

  typedef struct packed {
    logic [SZW-1:0] start;
    logic [SZW-1:0] len;
  } rng_ent_t;

  typedef struct packed {
    logic [31:0]    handle;
    logic [3:0]     owner;
    logic [SZW-1:0] start;
    logic [SZW-1:0] len;
  } buf_ent_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_SET_ST,
    CMD_RNG_RD,
    CMD_RIDX_INC,
    CMD_BIDX_INC,
    CMD_BUF_RD,
    CMD_ALLOC_COMMIT,
    CMD_RELEASE,
    CMD_LOOKUP_CHK,
    CMD_MAP_OK,
    CMD_USED_CLR,
    CMD_AR_START,
    CMD_AR_PREV,
    CMD_MBOTH,
    CMD_MPREV,
    CMD_MNEXT,
    CMD_INS_START,
    CMD_SD_RD,
    CMD_SD_WR,
    CMD_SD_END,
    CMD_SU_RD,
    CMD_SU_WR,
    CMD_SU_END,
    CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] pre_st;
    logic       r_end;
    logic       b_end;
    logic       fits;
    logic       exact;
    logic       slot_free;
    logic       own_hit;
    logic       hnd_hit;
    logic       map_hit;
    logic       rng_full;
    logic       after_ins;
    logic       m_prev;
    logic       m_next;
    logic       sd_last;
    logic       su_last;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/core/ffbpa_ctrl.sv =====
module ffbpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffbpa_pkg::stat_t stat,
  output ffbpa_pkg::cmd_t  cmd
);
  import ffbpa_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_A_RD, S_A_CMP, S_A_SLOT, S_FIND_RD, S_FIND_CMP,
    S_FO_RD, S_FO_CMP, S_MAP_RD, S_MAP_CMP, S_AR_BEGIN, S_AR_RD, S_AR_CMP,
    S_AR_DONE, S_SD_RD, S_SD_WR, S_SU_RD, S_SU_WR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NONE;
    cmd.st    = ST_OK;
    case (state_r)
      S_INIT: begin
        cmd.op    = CMD_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.pre_st != ST_OK) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = stat.pre_st;
          state_nxt = S_FIN;
        end else if (stat.op == OP_ALLOC) begin
          state_nxt = S_A_RD;
        end else if (stat.op == OP_FREE_OWNER) begin
          state_nxt = S_FO_RD;
        end else if (stat.op == OP_MAP) begin
          state_nxt = S_MAP_RD;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_A_RD: begin
        if (stat.r_end) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_NOMEM;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_RNG_RD;
          state_nxt = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (stat.fits) begin
          state_nxt = S_A_SLOT;
        end else begin
          cmd.op    = CMD_RIDX_INC;
          state_nxt = S_A_RD;
        end
      end
      S_A_SLOT: begin
        if (stat.b_end) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_NOMEM;
          state_nxt = S_FIN;
        end else if (stat.slot_free) begin
          cmd.op    = CMD_ALLOC_COMMIT;
          state_nxt = stat.exact ? S_SD_RD : S_FIN;
        end else begin
          cmd.op = CMD_BIDX_INC;
        end
      end
      S_FIND_RD: begin
        if (stat.b_end) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_NOTFOUND;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_BUF_RD;
          state_nxt = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (!stat.hnd_hit) begin
          cmd.op    = CMD_BIDX_INC;
          state_nxt = S_FIND_RD;
        end else if (stat.op == OP_LOOKUP) begin
          cmd.op    = CMD_LOOKUP_CHK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_RELEASE;
          state_nxt = S_AR_BEGIN;
        end
      end
      S_FO_RD: begin
        if (stat.b_end) begin
          cmd.op    = CMD_USED_CLR;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_BUF_RD;
          state_nxt = S_FO_CMP;
        end
      end
      S_FO_CMP: begin
        if (stat.own_hit) begin
          cmd.op    = CMD_RELEASE;
          state_nxt = S_AR_BEGIN;
        end else begin
          cmd.op    = CMD_BIDX_INC;
          state_nxt = S_FO_RD;
        end
      end
      S_MAP_RD: begin
        if (stat.b_end) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_INVALID;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_BUF_RD;
          state_nxt = S_MAP_CMP;
        end
      end
      S_MAP_CMP: begin
        if (stat.map_hit) begin
          cmd.op    = CMD_MAP_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_BIDX_INC;
          state_nxt = S_MAP_RD;
        end
      end
      S_AR_BEGIN: begin
        if (stat.rng_full) begin
          // bytes of the released buffer are dropped
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_NOMEM;
          state_nxt = S_AR_DONE;
        end else begin
          cmd.op    = CMD_AR_START;
          state_nxt = S_AR_RD;
        end
      end
      S_AR_RD: begin
        if (stat.r_end) begin
          if (stat.m_prev) begin
            cmd.op    = CMD_MPREV;
            state_nxt = S_AR_DONE;
          end else begin
            cmd.op    = CMD_INS_START;
            state_nxt = S_SU_RD;
          end
        end else begin
          cmd.op    = CMD_RNG_RD;
          state_nxt = S_AR_CMP;
        end
      end
      S_AR_CMP: begin
        if (!stat.after_ins) begin
          cmd.op    = CMD_AR_PREV;
          state_nxt = S_AR_RD;
        end else if (stat.m_prev && stat.m_next) begin
          cmd.op    = CMD_MBOTH;
          state_nxt = S_SD_RD;
        end else if (stat.m_prev) begin
          cmd.op    = CMD_MPREV;
          state_nxt = S_AR_DONE;
        end else if (stat.m_next) begin
          cmd.op    = CMD_MNEXT;
          state_nxt = S_AR_DONE;
        end else begin
          cmd.op    = CMD_INS_START;
          state_nxt = S_SU_RD;
        end
      end
      S_AR_DONE: begin
        if (stat.op == OP_FREE_OWNER) begin
          cmd.op    = CMD_BIDX_INC;
          state_nxt = S_FO_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SD_RD: begin
        if (stat.sd_last) begin
          cmd.op    = CMD_SD_END;
          state_nxt = S_AR_DONE;
        end else begin
          cmd.op    = CMD_SD_RD;
          state_nxt = S_SD_WR;
        end
      end
      S_SD_WR: begin
        cmd.op    = CMD_SD_WR;
        state_nxt = S_SD_RD;
      end
      S_SU_RD: begin
        if (stat.su_last) begin
          cmd.op    = CMD_SU_END;
          state_nxt = S_AR_DONE;
        end else begin
          cmd.op    = CMD_SU_RD;
          state_nxt = S_SU_WR;
        end
      end
      S_SU_WR: begin
        cmd.op    = CMD_SU_WR;
        state_nxt = S_SU_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = CMD_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

endmodule

// ===== rtl/core/ffbpa_dp.sv =====
module ffbpa_dp #(
  parameter int MAX_RANGES  = ffbpa_pkg::MAX_RANGES,
  parameter int MAX_BUFFERS = ffbpa_pkg::MAX_BUFFERS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  ffbpa_pkg::in_t   in_data,
  input  ffbpa_pkg::cmd_t  cmd,
  output ffbpa_pkg::stat_t stat,
  output logic             out_valid,
  input  logic             out_stall,
  output ffbpa_pkg::out_t  out_data
);
  import ffbpa_pkg::*;

  localparam int RIW = $clog2(MAX_RANGES);
  localparam int BIW = $clog2(MAX_BUFFERS);
  localparam int RCW = RIW + 1;
  localparam int BCW = BIW + 1;

  logic [SZW-1:0] max_buf_r, quota_r;
  logic [31:0]    mmap_base_r;
  logic [63:0]    dma_base_r;

  in_t  req_r;
  out_t res_r, out_r;
  logic out_valid_r;

  rng_ent_t rng_mem [MAX_RANGES];
  rng_ent_t rng_q_r, ins_r, prev_r;
  logic     have_prev_r;
  logic [RCW-1:0] rng_cnt_r, ridx_r, kidx_r;

  buf_ent_t buf_mem [MAX_BUFFERS];
  buf_ent_t buf_q_r;
  logic [MAX_BUFFERS-1:0] buf_vld_r;
  logic [BCW-1:0] bidx_r;

  logic [SZW-1:0] used_r [MAX_OWNERS];
  logic [31:0]    hctr_r;

  // combinational helpers
  logic           owner_bad;
  logic [32:0]    size33;
  logic [SZW-1:0] size;
  logic [SZW-1:0] used;
  logic [31:0]    pool_diff;
  logic [SZW-1:0] poff, inbuf;
  logic [2:0]     pre_st;
  logic           vld_cur;
  logic [31:0]    hctr_inc;
  logic [RCW-1:0] ridx_m1, kidx_p1, kidx_m1;

  logic           rng_re, rng_we;
  logic [RIW-1:0] rng_raddr, rng_waddr;
  rng_ent_t       rng_wdata;

  assign owner_bad = (req_r.owner_id == 4'd0) ||
                     ({1'b0, req_r.owner_id} >= 5'(MAX_OWNERS));
  assign size33    = (33'(req_r.alloc_bytes) + 33'(PAGE_BYTES - 1)) &
                     ~33'(PAGE_BYTES - 1);
  assign size      = size33[SZW-1:0];
  assign used      = used_r[req_r.owner_id];
  assign pool_diff = req_r.data_offset - mmap_base_r;
  assign poff      = pool_diff[SZW-1:0];
  assign inbuf     = poff - buf_q_r.start;
  assign vld_cur   = buf_vld_r[bidx_r[BIW-1:0]];
  assign hctr_inc  = hctr_r + 32'd1;
  assign ridx_m1   = ridx_r - RCW'(1);
  assign kidx_p1   = kidx_r + RCW'(1);
  assign kidx_m1   = kidx_r - RCW'(1);

  always_comb begin
    case (req_r.opcode)
      OP_ALLOC: begin
        if (owner_bad || req_r.alloc_bytes == 32'd0 ||
            req_r.alloc_bytes > {7'd0, max_buf_r} || size33 > {8'd0, max_buf_r})
          pre_st = ST_INVALID;
        else if (used > quota_r || size33 > {8'd0, quota_r - used})
          pre_st = ST_QUOTA;
        else
          pre_st = ST_OK;
      end
      OP_FREE: pre_st = (owner_bad || req_r.handle == 32'd0) ? ST_INVALID : ST_OK;
      OP_FREE_OWNER: pre_st = owner_bad ? ST_INVALID : ST_OK;
      OP_LOOKUP: begin
        pre_st = (owner_bad || req_r.handle == 32'd0 || req_r.length == 32'd0) ?
                 ST_INVALID : ST_OK;
      end
      OP_MAP: begin
        if (owner_bad)
          pre_st = ST_NODEV;
        else if (req_r.data_offset < mmap_base_r || pool_diff > 32'(POOL_BYTES))
          pre_st = ST_INVALID;
        else
          pre_st = ST_OK;
      end
      default: pre_st = ST_INVALID;
    endcase
  end

  always_comb begin
    stat.op        = req_r.opcode;
    stat.pre_st    = pre_st;
    stat.r_end     = (ridx_r == rng_cnt_r);
    stat.b_end     = (bidx_r == BCW'(MAX_BUFFERS));
    stat.fits      = (rng_q_r.len >= size);
    stat.exact     = (rng_q_r.len == size);
    stat.slot_free = !vld_cur;
    stat.own_hit   = vld_cur && (buf_q_r.owner == req_r.owner_id);
    stat.hnd_hit   = stat.own_hit && (buf_q_r.handle == req_r.handle);
    stat.map_hit   = stat.own_hit && (poff >= buf_q_r.start) &&
                     (inbuf <= buf_q_r.len) &&
                     (req_r.length <= {7'd0, buf_q_r.len - inbuf});
    stat.rng_full  = (rng_cnt_r == RCW'(MAX_RANGES));
    stat.after_ins = (rng_q_r.start > ins_r.start);
    stat.m_prev    = have_prev_r &&
                     ({1'b0, prev_r.start} + {1'b0, prev_r.len} == {1'b0, ins_r.start});
    stat.m_next    = ({1'b0, ins_r.start} + {1'b0, ins_r.len} == {1'b0, rng_q_r.start});
    stat.sd_last   = (kidx_p1 == rng_cnt_r);
    stat.su_last   = (kidx_r == ridx_r);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // range table port selection
  always_comb begin
    rng_re    = 1'b0;
    rng_raddr = ridx_r[RIW-1:0];
    rng_we    = 1'b0;
    rng_waddr = ridx_r[RIW-1:0];
    rng_wdata = rng_q_r;
    case (cmd.op)
      CMD_RNG_RD: rng_re = 1'b1;
      CMD_SD_RD: begin
        rng_re    = 1'b1;
        rng_raddr = kidx_p1[RIW-1:0];
      end
      CMD_SU_RD: begin
        rng_re    = 1'b1;
        rng_raddr = kidx_m1[RIW-1:0];
      end
      CMD_INIT: begin
        rng_we    = 1'b1;
        rng_waddr = '0;
        rng_wdata = '{start: '0, len: SZW'(POOL_BYTES)};
      end
      CMD_ALLOC_COMMIT: begin
        rng_we    = !stat.exact;
        rng_wdata = '{start: rng_q_r.start + size, len: rng_q_r.len - size};
      end
      CMD_MBOTH: begin
        rng_we    = 1'b1;
        rng_waddr = ridx_m1[RIW-1:0];
        rng_wdata = '{start: prev_r.start, len: prev_r.len + ins_r.len + rng_q_r.len};
      end
      CMD_MPREV: begin
        rng_we    = 1'b1;
        rng_waddr = ridx_m1[RIW-1:0];
        rng_wdata = '{start: prev_r.start, len: prev_r.len + ins_r.len};
      end
      CMD_MNEXT: begin
        rng_we    = 1'b1;
        rng_wdata = '{start: ins_r.start, len: ins_r.len + rng_q_r.len};
      end
      CMD_SD_WR, CMD_SU_WR: begin
        rng_we    = 1'b1;
        rng_waddr = kidx_r[RIW-1:0];
      end
      CMD_SU_END: begin
        rng_we    = 1'b1;
        rng_wdata = ins_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rng_we)
      rng_mem[rng_waddr] <= rng_wdata;
    if (rng_re)
      rng_q_r <= rng_mem[rng_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_ALLOC_COMMIT)
      buf_mem[bidx_r[BIW-1:0]] <= '{handle: hctr_r, owner: req_r.owner_id,
                                    start: rng_q_r.start, len: size};
    if (cmd.op == CMD_BUF_RD)
      buf_q_r <= buf_mem[bidx_r[BIW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_buf_r   <= SZW'(16777216);
      quota_r     <= SZW'(16777216);
      mmap_base_r <= '0;
      dma_base_r  <= '0;
      out_valid_r <= 1'b0;
      rng_cnt_r   <= RCW'(1);
      ridx_r      <= '0;
      bidx_r      <= '0;
      kidx_r      <= '0;
      have_prev_r <= 1'b0;
      buf_vld_r   <= '0;
      hctr_r      <= 32'd1;
      for (int i = 0; i < MAX_OWNERS; i++)
        used_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_BUF: max_buf_r   <= cfg_data[SZW-1:0];
          REG_QUOTA:   quota_r     <= cfg_data[SZW-1:0];
          REG_MMAP:    mmap_base_r <= cfg_data[31:0];
          REG_DMA:     dma_base_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == CMD_PUBLISH)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
      case (cmd.op)
        CMD_INIT: rng_cnt_r <= RCW'(1);
        CMD_LOAD: begin
          ridx_r <= '0;
          bidx_r <= '0;
        end
        CMD_RIDX_INC: ridx_r <= ridx_r + RCW'(1);
        CMD_BIDX_INC: bidx_r <= bidx_r + BCW'(1);
        CMD_ALLOC_COMMIT: begin
          buf_vld_r[bidx_r[BIW-1:0]] <= 1'b1;
          hctr_r <= (hctr_inc == 32'd0) ? 32'd1 : hctr_inc;
          used_r[req_r.owner_id] <= used + size;
          kidx_r <= ridx_r;
        end
        CMD_RELEASE: begin
          buf_vld_r[bidx_r[BIW-1:0]] <= 1'b0;
          if (req_r.opcode == OP_FREE)
            used_r[req_r.owner_id] <= (used >= buf_q_r.len) ? used - buf_q_r.len : '0;
        end
        CMD_USED_CLR: used_r[req_r.owner_id] <= '0;
        CMD_AR_START: begin
          ridx_r      <= '0;
          have_prev_r <= 1'b0;
        end
        CMD_AR_PREV: begin
          have_prev_r <= 1'b1;
          ridx_r      <= ridx_r + RCW'(1);
        end
        CMD_MBOTH:     kidx_r    <= ridx_r;
        CMD_INS_START: kidx_r    <= rng_cnt_r;
        CMD_SD_WR:     kidx_r    <= kidx_p1;
        CMD_SD_END:    rng_cnt_r <= rng_cnt_r - RCW'(1);
        CMD_SU_WR:     kidx_r    <= kidx_m1;
        CMD_SU_END:    rng_cnt_r <= rng_cnt_r + RCW'(1);
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        req_r <= in_data;
        res_r <= '0;
      end
      CMD_SET_ST: res_r.status <= cmd.st;
      CMD_ALLOC_COMMIT: begin
        res_r.status       <= ST_OK;
        res_r.new_handle   <= hctr_r;
        res_r.map_offset   <= mmap_base_r + {7'd0, rng_q_r.start};
        res_r.granted_size <= size;
      end
      CMD_RELEASE: ins_r <= '{start: buf_q_r.start, len: buf_q_r.len};
      CMD_LOOKUP_CHK: begin
        if (req_r.data_offset > {7'd0, buf_q_r.len} ||
            req_r.length > {7'd0, buf_q_r.len} - req_r.data_offset) begin
          res_r.status <= ST_INVALID;
        end else begin
          res_r.status      <= ST_OK;
          res_r.dma_address <= dma_base_r + {39'd0, buf_q_r.start} +
                               {32'd0, req_r.data_offset};
        end
      end
      CMD_MAP_OK: begin
        res_r.status     <= ST_OK;
        res_r.page_index <= 13'(poff >> PAGE_SH);
      end
      CMD_USED_CLR: res_r.status <= ST_OK;
      CMD_AR_PREV: prev_r <= rng_q_r;
      CMD_PUBLISH: out_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/first_fit_buffer_pool_allocator.sv =====
// First-fit buffer pool allocator. Requests (allocate, free handle, free owner,
// DMA lookup, mapping check) are taken one at a time; each gives one result.
// Free ranges live in a sorted, packed table; buffers in a slot table with
// per-slot valid flags. Run time is set by table walks through single-port
// memories: it grows with each range entry scanned, each buffer slot probed
// for a free slot or searched, and each range entry moved when a range is
// inserted or removed; free owner repeats the free-range insert once per
// released buffer. After reset the block initializes the range table before
// it takes its first request.
// Configuration writes are taken at any time but should be made while idle.
module first_fit_buffer_pool_allocator #(
  parameter int MAX_RANGES  = ffbpa_pkg::MAX_RANGES,
  parameter int MAX_BUFFERS = ffbpa_pkg::MAX_BUFFERS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  ffbpa_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ffbpa_pkg::out_t out_data
);
  import ffbpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffbpa_dp #(
    .MAX_RANGES  (MAX_RANGES),
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/first_fit_buffer_pool_allocator_test.sv =====
module first_fit_buffer_pool_allocator_test;
  import ffbpa_pkg::*;

  localparam logic [3:0] REG_UNUSED = 4'd9;
  localparam int RANDOM_ITEMS = 1450;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [3:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  first_fit_buffer_pool_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // allocator state as predicted
  bit          rng_vld[MAX_RANGES];
  int unsigned rng_start[MAX_RANGES];
  int unsigned rng_len[MAX_RANGES];
  bit          buf_vld[MAX_BUFFERS];
  int unsigned buf_hnd[MAX_BUFFERS];
  int unsigned buf_start[MAX_BUFFERS];
  int unsigned buf_len[MAX_BUFFERS];
  logic [3:0]  buf_own[MAX_BUFFERS];
  int unsigned owner_bytes[MAX_OWNERS];
  int unsigned next_handle;
  int unsigned cap_bytes;
  int unsigned quota_bytes;
  int unsigned map_base;
  longint unsigned bus_base;

  out_t expected_results[$];
  out_t last_result;
  int errors;
  bit quiet;
  bit long_hold;
  bit in_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000000;
    $display("first_fit_buffer_pool_allocator_test: errors");
    $finish;
  end

  function automatic logic [2:0] range_insert(int unsigned s, int unsigned l);
    int unsigned ts[MAX_RANGES];
    int unsigned tl[MAX_RANGES];
    int slot;
    int n;
    int j;
    slot = -1;
    n = 0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (!rng_vld[i] && slot < 0) slot = i;
    end
    if (slot < 0) return ST_NOMEM;
    rng_vld[slot] = 1'b1;
    rng_start[slot] = s;
    rng_len[slot] = l;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (rng_vld[i]) begin
        j = n;
        while (j > 0 && ts[j-1] > rng_start[i]) begin
          ts[j] = ts[j-1];
          tl[j] = tl[j-1];
          j--;
        end
        ts[j] = rng_start[i];
        tl[j] = rng_len[i];
        n++;
      end
    end
    for (int i = 0; i < MAX_RANGES; i++) begin
      rng_vld[i] = 1'b0;
      rng_start[i] = 0;
      rng_len[i] = 0;
    end
    j = -1;
    for (int i = 0; i < n; i++) begin
      if (j >= 0 && 64'(rng_start[j]) + rng_len[j] == ts[i]) begin
        rng_len[j] += tl[i];
      end else begin
        j++;
        rng_vld[j] = 1'b1;
        rng_start[j] = ts[i];
        rng_len[j] = tl[i];
      end
    end
    return ST_OK;
  endfunction

  function automatic int find_buf(logic [3:0] own, int unsigned h);
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      if (buf_vld[i] && buf_own[i] == own && buf_hnd[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic void release_slot(int b);
    buf_vld[b] = 1'b0;
    buf_hnd[b] = 0;
    buf_start[b] = 0;
    buf_len[b] = 0;
    buf_own[b] = 0;
  endfunction

  function automatic out_t allocator_predict(in_t r);
    out_t o;
    longint unsigned sz;
    int slot;
    int b;
    int unsigned po;
    int unsigned inb;
    o = '0;
    o.status = ST_INVALID;
    case (r.opcode)
      OP_ALLOC: begin
        sz = ((64'(r.alloc_bytes) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        if (r.owner_id == 0 || r.alloc_bytes == 0 || r.alloc_bytes > cap_bytes ||
            sz > cap_bytes) begin
          o.status = ST_INVALID;
        end else if (owner_bytes[r.owner_id] > quota_bytes ||
                     sz > 64'(quota_bytes - owner_bytes[r.owner_id])) begin
          o.status = ST_QUOTA;
        end else begin
          o.status = ST_NOMEM;
          for (int i = 0; i < MAX_RANGES; i++) begin
            if (rng_vld[i] && rng_len[i] >= sz) begin
              slot = -1;
              for (int k = 0; k < MAX_BUFFERS; k++) begin
                if (!buf_vld[k] && slot < 0) slot = k;
              end
              if (slot >= 0) begin
                buf_vld[slot] = 1'b1;
                buf_hnd[slot] = next_handle;
                buf_start[slot] = rng_start[i];
                buf_len[slot] = 32'(sz);
                buf_own[slot] = r.owner_id;
                rng_start[i] = rng_start[i] + 32'(sz);
                rng_len[i] = rng_len[i] - 32'(sz);
                if (rng_len[i] == 0) begin
                  rng_vld[i] = 1'b0;
                  rng_start[i] = 0;
                end
                next_handle++;
                if (next_handle == 0) next_handle = 1;
                owner_bytes[r.owner_id] = (owner_bytes[r.owner_id] + 32'(sz)) & 32'h1FF_FFFF;
                o.status = ST_OK;
                o.new_handle = buf_hnd[slot];
                o.map_offset = map_base + buf_start[slot];
                o.granted_size = SZW'(sz);
              end
              break;
            end
          end
        end
      end
      OP_FREE: begin
        if (r.owner_id != 0 && r.handle != 0) begin
          b = find_buf(r.owner_id, r.handle);
          if (b < 0) begin
            o.status = ST_NOTFOUND;
          end else begin
            po = buf_start[b];
            inb = buf_len[b];
            release_slot(b);
            owner_bytes[r.owner_id] = owner_bytes[r.owner_id] >= inb ?
                                      owner_bytes[r.owner_id] - inb : 0;
            o.status = range_insert(po, inb);
          end
        end
      end
      OP_FREE_OWNER: begin
        if (r.owner_id != 0) begin
          for (int i = 0; i < MAX_BUFFERS; i++) begin
            if (buf_vld[i] && buf_own[i] == r.owner_id) begin
              void'(range_insert(buf_start[i], buf_len[i]));
              release_slot(i);
            end
          end
          owner_bytes[r.owner_id] = 0;
          o.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (r.owner_id != 0 && r.handle != 0 && r.length != 0) begin
          b = find_buf(r.owner_id, r.handle);
          if (b < 0) begin
            o.status = ST_NOTFOUND;
          end else if (!(r.data_offset > buf_len[b] ||
                         r.length > buf_len[b] - r.data_offset)) begin
            o.status = ST_OK;
            o.dma_address = bus_base + buf_start[b] + r.data_offset;
          end
        end
      end
      OP_MAP: begin
        if (r.owner_id == 0) begin
          o.status = ST_NODEV;
        end else if (r.data_offset >= map_base &&
                     r.data_offset - map_base <= POOL_BYTES) begin
          po = r.data_offset - map_base;
          for (int i = 0; i < MAX_BUFFERS; i++) begin
            if (buf_vld[i] && buf_own[i] == r.owner_id && po >= buf_start[i]) begin
              inb = po - buf_start[i];
              if (inb <= buf_len[i] && r.length <= buf_len[i] - inb) begin
                o.status = ST_OK;
                o.page_index = 13'(po / PAGE_BYTES);
                break;
              end
            end
          end
        end
      end
      default: o.status = ST_INVALID;
    endcase
    return o;
  endfunction

  task automatic send_request(in_t r);
    int gap;
    gap = (in_gaps && !quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    last_result = allocator_predict(r);
    expected_results.push_back(last_result);
    // the block takes one request at a time; drop valid once it is accepted
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic req(logic [2:0] op, logic [3:0] own, logic [31:0] sz, logic [31:0] h,
                     logic [31:0] off, logic [31:0] len);
    in_t r;
    r.opcode = op;
    r.owner_id = own;
    r.alloc_bytes = sz;
    r.handle = h;
    r.data_offset = off;
    r.length = len;
    send_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_BUF: cap_bytes = 32'(val[24:0]);
      REG_QUOTA:   quota_bytes = 32'(val[24:0]);
      REG_MMAP:    map_base = val[31:0];
      REG_DMA:     bus_base = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned cap, int unsigned quota, int unsigned mb,
                            longint unsigned db);
    drain();
    write_reg(REG_MAX_BUF, 64'(cap));
    write_reg(REG_QUOTA, 64'(quota));
    write_reg(REG_MMAP, 64'(mb));
    write_reg(REG_DMA, db);
  endtask

  // receiver stall: random bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.new_handle !== e.new_handle) begin
          $display("%0t: new_handle exp %h got %h", $time, e.new_handle, out_data.new_handle);
          errors++;
        end
        if (out_data.map_offset !== e.map_offset) begin
          $display("%0t: map_offset exp %h got %h", $time, e.map_offset, out_data.map_offset);
          errors++;
        end
        if (out_data.granted_size !== e.granted_size) begin
          $display("%0t: granted_size exp %h got %h", $time, e.granted_size,
                   out_data.granted_size);
          errors++;
        end
        if (out_data.dma_address !== e.dma_address) begin
          $display("%0t: dma_address exp %h got %h", $time, e.dma_address,
                   out_data.dma_address);
          errors++;
        end
        if (out_data.page_index !== e.page_index) begin
          $display("%0t: page_index exp %h got %h", $time, e.page_index, out_data.page_index);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_pool();
    req(OP_FREE, 4'd1, 0, 32'd1, 0, 0);
    req(OP_LOOKUP, 4'd1, 0, 32'd1, 0, 32'd1);
    req(OP_MAP, 4'd1, 0, 0, 0, 0);
    req(3'd5, 4'd1, 0, 0, 0, 0);
    req(3'd7, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    req(OP_ALLOC, 4'd0, 32'd4096, 0, 0, 0);
    req(OP_FREE, 4'd0, 0, 32'd1, 0, 0);
    req(OP_FREE_OWNER, 4'd0, 0, 0, 0, 0);
    req(OP_LOOKUP, 4'd0, 0, 32'd1, 0, 32'd1);
    req(OP_MAP, 4'd0, 0, 0, 0, 0);
  endtask

  task automatic test_alloc_edges();
    int unsigned h;
    int unsigned mo;
    req(OP_ALLOC, 4'd1, 32'd0, 0, 0, 0);
    req(OP_ALLOC, 4'd1, 32'hFFFF_FFFF, 0, 0, 0);
    req(OP_ALLOC, 4'd1, 32'd16777217, 0, 0, 0);
    req(OP_ALLOC, 4'd1, 32'd1, 0, 0, 0);
    req(OP_ALLOC, 4'd1, 32'd4097, 0, 0, 0);
    h = last_result.new_handle;
    mo = last_result.map_offset;
    req(OP_LOOKUP, 4'd1, 0, h, 32'd8191, 32'd1);
    req(OP_LOOKUP, 4'd1, 0, h, 32'd8192, 32'd1);
    req(OP_LOOKUP, 4'd1, 0, h, 32'd0, 32'd0);
    req(OP_LOOKUP, 4'd2, 0, h, 32'd0, 32'd1);
    req(OP_MAP, 4'd1, 0, 0, mo + 32'd8192, 32'd0);
    req(OP_MAP, 4'd1, 0, 0, mo + 32'd4096, 32'd4097);
    req(OP_MAP, 4'd1, 0, 0, 32'hFFFF_FFFF, 32'd1);
    req(OP_FREE, 4'd1, 0, h, 0, 0);
    req(OP_FREE, 4'd1, 0, h, 0, 0);
    req(OP_ALLOC, 4'd2, 32'd16777216, 0, 0, 0);
    req(OP_ALLOC, 4'd3, 32'd1, 0, 0, 0);
    req(OP_FREE_OWNER, 4'd2, 0, 0, 0, 0);
    req(OP_FREE_OWNER, 4'd1, 0, 0, 0, 0);
  endtask

  task automatic test_limits();
    set_config(32'd5000, 32'd8192, 32'hFFFF_F000, 64'hFFFF_FFFF_FFFF_F000);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    req(OP_ALLOC, 4'd3, 32'd4097, 0, 0, 0);
    req(OP_ALLOC, 4'd3, 32'd4096, 0, 0, 0);
    req(OP_ALLOC, 4'd3, 32'd4096, 0, 0, 0);
    req(OP_LOOKUP, 4'd3, 0, last_result.new_handle, 32'd4095, 32'd1);
    req(OP_ALLOC, 4'd3, 32'd1, 0, 0, 0);
    set_config(32'd0, 32'd0, 32'd0, 64'd0);
    req(OP_ALLOC, 4'd3, 32'd1, 0, 0, 0);
    req(OP_ALLOC, 4'd4, 32'd1, 0, 0, 0);
    req(OP_FREE_OWNER, 4'd3, 0, 0, 0, 0);
    set_config(32'd16777216, 32'd16777216, 32'd0, 64'd0);
  endtask

  // fill the buffer table, then punch holes that merge on either side
  task automatic test_table_full();
    int unsigned hs[$];
    for (int i = 0; i <= MAX_BUFFERS; i++) begin
      req(OP_ALLOC, 4'd5, 32'd4096, 0, 0, 0);
      hs.push_back(last_result.new_handle);
    end
    req(OP_FREE, 4'd5, 0, hs[10], 0, 0);
    req(OP_FREE, 4'd5, 0, hs[12], 0, 0);
    req(OP_FREE, 4'd5, 0, hs[11], 0, 0);
    req(OP_FREE, 4'd5, 0, hs[127], 0, 0);
    req(OP_FREE, 4'd5, 0, hs[0], 0, 0);
    req(OP_ALLOC, 4'd6, 32'd12288, 0, 0, 0);
    req(OP_FREE_OWNER, 4'd5, 0, 0, 0, 0);
    req(OP_FREE_OWNER, 4'd6, 0, 0, 0, 0);
  endtask

  task automatic test_back_pressure();
    drain();
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) req(OP_ALLOC, 4'd7, 32'd100, 0, 0, 0);
    req(OP_FREE_OWNER, 4'd7, 0, 0, 0, 0);
  endtask

  function automatic int pick_buffer();
    int live[$];
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      if (buf_vld[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic random_request();
    in_t r;
    int b;
    int unsigned w;
    int unsigned inb;
    r.opcode = OP_ALLOC;
    r.owner_id = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    r.alloc_bytes = $urandom;
    r.handle = $urandom;
    r.data_offset = $urandom;
    r.length = $urandom;
    w = $urandom_range(0, 99);
    b = pick_buffer();
    if (w < 36) begin
      r.alloc_bytes = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300000);
    end else if (w < 58) begin
      r.opcode = OP_FREE;
      if (b >= 0 && $urandom_range(0, 4) != 0) begin
        r.owner_id = buf_own[b];
        r.handle = buf_hnd[b];
      end
    end else if (w < 78) begin
      r.opcode = OP_LOOKUP;
      if (b >= 0 && $urandom_range(0, 4) != 0) begin
        r.owner_id = buf_own[b];
        r.handle = buf_hnd[b];
        r.data_offset = $urandom_range(0, buf_len[b]);
        r.length = $urandom_range(0, buf_len[b] - r.data_offset + 1);
      end
    end else if (w < 94) begin
      r.opcode = OP_MAP;
      if (b >= 0 && $urandom_range(0, 4) != 0) begin
        inb = $urandom_range(0, buf_len[b]);
        r.owner_id = buf_own[b];
        r.data_offset = map_base + buf_start[b] + inb;
        r.length = $urandom_range(0, buf_len[b] - inb + 1);
      end
    end else if (w < 97) begin
      r.opcode = OP_FREE_OWNER;
    end else begin
      r.opcode = 3'($urandom_range(5, 7));
    end
    send_request(r);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 4) set_config(32'd65536, 32'd200000, 32'hFFF0_0000, {$urandom, $urandom});
      if (i == n / 2) set_config(32'd16777216, 32'd1000000, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
      if (i == 3 * n / 4) set_config(32'd16777216, 32'd16777216, 32'd0, 64'd0);
      if (i == n - 150) quiet = 1'b1;
      random_request();
    end
  endtask

  initial begin
    errors = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    in_gaps = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      rng_vld[i] = 1'b0;
      rng_start[i] = 0;
      rng_len[i] = 0;
    end
    rng_vld[0] = 1'b1;
    rng_len[0] = POOL_BYTES;
    for (int i = 0; i < MAX_BUFFERS; i++) release_slot(i);
    for (int i = 0; i < MAX_OWNERS; i++) owner_bytes[i] = 0;
    next_handle = 1;
    cap_bytes = 16777216;
    quota_bytes = 16777216;
    map_base = 0;
    bus_base = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pool();
    test_alloc_edges();
    test_limits();
    test_table_full();
    test_back_pressure();
    test_random(RANDOM_ITEMS);

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("first_fit_buffer_pool_allocator_test: clean");
    end else begin
      $display("first_fit_buffer_pool_allocator_test: errors");
    end
    $finish;
  end

endmodule
